// ===== rtl/sarc_pkg.sv =====
package sarc_pkg;

   localparam int AxisW       = 16;
   localparam int OutW        = 20;
   localparam int GainW       = 11;
   localparam int DzW         = 15;
   localparam int NumAxes     = 6;
   localparam int LaneLatency = 4;
   localparam int CntW        = $clog2(LaneLatency + 1);
   localparam int CsrIdxW     = 3;
   localparam int CsrDataW    = 15;

   localparam logic [GainW-1:0] GainMin    = 11'd26;
   localparam logic [GainW-1:0] GainMax    = 11'd1280;
   localparam logic [GainW-1:0] GainReset  = 11'd256;
   localparam logic [DzW-1:0]   DzReset    = 15'd50;
   localparam logic [7:0]       IdMotion   = 8'h01;
   localparam logic [7:0]       IdButton   = 8'h03;
   localparam logic [6:0]       MinLen     = 7'd7;
   localparam logic [6:0]       MotionLen  = 7'd13;
   localparam int               BtnLeft    = 0;
   localparam int               BtnRight   = 1;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_INPUT_ENABLE = 3'd0,
      CSR_DEAD_ZONE    = 3'd1,
      CSR_CUBIC_ENABLE = 3'd2,
      CSR_MOVE_GAIN    = 3'd3,
      CSR_TURN_GAIN    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_MOTION,
      KIND_BUTTON
   } kind_type;

   typedef struct packed {
      logic [7:0]              report_id;
      logic [6:0]              report_length;
      logic signed [AxisW-1:0] move_x;
      logic signed [AxisW-1:0] move_y;
      logic signed [AxisW-1:0] move_z;
      logic signed [AxisW-1:0] turn_x;
      logic signed [AxisW-1:0] turn_y;
      logic signed [AxisW-1:0] turn_z;
      logic [7:0]              button_bits;
   } sarc_req_type;

   typedef struct packed {
      logic                   move_changed;
      logic                   turn_changed;
      logic signed [OutW-1:0] out_move_x;
      logic signed [OutW-1:0] out_move_y;
      logic signed [OutW-1:0] out_move_z;
      logic signed [OutW-1:0] out_turn_x;
      logic signed [OutW-1:0] out_turn_y;
      logic signed [OutW-1:0] out_turn_z;
      logic                   left_press;
      logic                   right_press;
   } sarc_rsp_type;

   typedef struct packed {
      logic       commit;
      kind_type   kind;
      logic [7:0] buttons;
   } sarc_ctrl_type;

   function automatic logic [GainW-1:0] clamp_gain(input logic [GainW-1:0] g);
      logic [GainW-1:0] r;
      r = g;
      if (g < GainMin) r = GainMin;
      if (g > GainMax) r = GainMax;
      return r;
   endfunction

endpackage

// ===== rtl/sarc_lane.sv =====
module sarc_lane import sarc_pkg::*; (
   input  logic                    clock,
   input  logic signed [AxisW-1:0] axis,
   input  logic [DzW-1:0]          dead_zone,
   input  logic                    cubic_enable,
   input  logic [GainW-1:0]        gain,
   input  logic                    rot,
   output logic signed [OutW-1:0]  result
);

   // stage 1: magnitude, dead zone, Q1.15 normalize, square
   logic               neg_in;
   logic [AxisW:0]     ext_in;
   logic [AxisW:0]     mag_in;
   logic [AxisW:0]     bump_in;
   logic [AxisW-1:0]   norm_in;
   logic [31:0]        sq_in;
   logic               neg1_ff;
   logic [AxisW-1:0]   norm1_ff;
   logic [31:0]        sq1_ff;

   always_comb begin
      neg_in  = axis[AxisW-1];
      ext_in  = {axis[AxisW-1], axis};
      mag_in  = neg_in ? (~ext_in + 17'd1) : ext_in;
      // round up once the fraction mag/32767 reaches one half
      bump_in = mag_in + {16'd0, (mag_in >= 17'd16384)};
      norm_in = (bump_in > 17'd32768) ? 16'd32768 : bump_in[AxisW-1:0];
      if (mag_in < {2'b00, dead_zone}) begin
         norm_in = '0;
      end
      sq_in   = {16'd0, norm_in} * {16'd0, norm_in};
   end

   always_ff @(posedge clock) begin
      neg1_ff  <= neg_in;
      norm1_ff <= norm_in;
      sq1_ff   <= sq_in;
   end

   // stage 2: cube
   logic [47:0]      cube_in;
   logic [47:0]      cube2_ff;
   logic [AxisW-1:0] norm2_ff;
   logic             neg2_ff;

   assign cube_in = {16'd0, sq1_ff} * {32'd0, norm1_ff};

   always_ff @(posedge clock) begin
      cube2_ff <= cube_in;
      norm2_ff <= norm1_ff;
      neg2_ff  <= neg1_ff;
   end

   // stage 3: response curve select, gain
   logic [47:0]      rnd_in;
   logic [AxisW-1:0] curve_in;
   logic [26:0]      prod_in;
   logic [26:0]      prod3_ff;
   logic             neg3_ff;

   always_comb begin
      rnd_in   = cube2_ff + 48'h0000_2000_0000;
      curve_in = cubic_enable ? rnd_in[45:30] : norm2_ff;
      prod_in  = {11'd0, curve_in} * {16'd0, gain};
   end

   always_ff @(posedge clock) begin
      prod3_ff <= prod_in;
      neg3_ff  <= neg2_ff;
   end

   // stage 4: round, rescale (rotation folds in the factor two), restore sign
   logic [26:0]          sum_in;
   logic [OutW-2:0]      scaled_in;
   logic signed [OutW-1:0] res_in;
   logic signed [OutW-1:0] res4_ff;

   always_comb begin
      if (rot) begin
         sum_in    = prod3_ff + 27'd64;
         scaled_in = sum_in[25:7];
      end else begin
         sum_in    = prod3_ff + 27'd128;
         scaled_in = sum_in[26:8];
      end
      res_in = neg3_ff ? -$signed({1'b0, scaled_in}) : $signed({1'b0, scaled_in});
   end

   always_ff @(posedge clock) begin
      res4_ff <= res_in;
   end

   assign result = res4_ff;

endmodule

// ===== rtl/sarc_merge.sv =====
module sarc_merge import sarc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear,
   input  sarc_ctrl_type          ctrl,
   input  logic signed [OutW-1:0] lane_result [NumAxes],
   output logic                   emit,
   output sarc_rsp_type           result
);

   logic signed [OutW-1:0] last_move_ff [3];
   logic signed [OutW-1:0] last_turn_ff [3];
   logic                   left_held_ff;
   logic                   right_held_ff;

   logic signed [OutW-1:0] mv [3];
   logic signed [OutW-1:0] tv [3];
   logic                   mc;
   logic                   tc;
   logic                   lp;
   logic                   rp;

   always_comb begin
      mv[0] = lane_result[0];
      mv[1] = -lane_result[1];
      mv[2] = -lane_result[2];
      tv[0] = lane_result[3];
      tv[1] = lane_result[4];
      tv[2] = lane_result[5];
      mc = 1'b0;
      tc = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (mv[i] != last_move_ff[i]) mc = 1'b1;
         if (tv[i] != last_turn_ff[i]) tc = 1'b1;
      end
      lp = ctrl.buttons[BtnLeft] & ~left_held_ff;
      rp = ctrl.buttons[BtnRight] & ~right_held_ff;
   end

   always_comb begin
      emit   = 1'b0;
      result = '0;
      case (ctrl.kind)
         KIND_MOTION: begin
            emit                = ctrl.commit && (mc || tc);
            result.move_changed = mc;
            result.turn_changed = tc;
            result.out_move_x   = mv[0];
            result.out_move_y   = mv[1];
            result.out_move_z   = mv[2];
            result.out_turn_x   = tv[0];
            result.out_turn_y   = tv[1];
            result.out_turn_z   = tv[2];
         end
         KIND_BUTTON: begin
            emit               = ctrl.commit && (lp || rp);
            result.left_press  = lp;
            result.right_press = rp;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int i = 0; i < 3; i++) begin
            last_move_ff[i] <= '0;
            last_turn_ff[i] <= '0;
         end
      end else if (ctrl.commit && ctrl.kind == KIND_MOTION) begin
         for (int i = 0; i < 3; i++) begin
            if (mc) last_move_ff[i] <= mv[i];
            if (tc) last_turn_ff[i] <= tv[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_held_ff  <= 1'b0;
         right_held_ff <= 1'b0;
      end else if (ctrl.commit && ctrl.kind == KIND_BUTTON) begin
         left_held_ff  <= ctrl.buttons[BtnLeft];
         right_held_ff <= ctrl.buttons[BtnRight];
      end
   end

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      clear |=> (last_move_ff[0] == '0 && last_move_ff[1] == '0 && last_move_ff[2] == '0 &&
                 last_turn_ff[0] == '0 && last_turn_ff[1] == '0 && last_turn_ff[2] == '0))
      else $error("stored vectors not cleared");

   a_held_only_on_button: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.commit && ctrl.kind == KIND_BUTTON) |=> $stable({left_held_ff, right_held_ff}))
      else $error("button state changed outside a button report");

endmodule

// ===== rtl/six_axis_report_conditioner.sv =====
// Six-axis report conditioner.
//
// Request channel (req_valid / req_stall / req_data) carries one input report:
// id, length, six raw axes and the button byte. A transfer happens on a rising
// edge with valid high and stall low. Motion reports run the six axes through
// six parallel lanes (dead zone, Q1.15 normalize, cubic curve, gain); a merge
// stage negates translation y and z, compares with the stored vectors and
// builds the result. Button reports produce press edges.
// Response channel (rsp_valid / rsp_stall / rsp_data) returns at most one
// result per report; reports that change nothing give no transfer.
// A motion or button report passes the four lane register stages and
// commits in the merge; the result is shown from the output register the
// cycle after. The lanes hold one report at a time: the next report is taken
// in the cycle its predecessor commits, and ignored reports do not occupy the
// lanes. A result waiting in the output register does not block the next
// report, but a report that finishes while the output is still stalled holds in the lanes until the output is taken.
// Reset (synchronous) clears the stored vectors, held buttons and loads the
// register defaults; input_enable comes up 0, so reports are dropped until
// it is written. csr_* writes take effect at once; index beyond the list is
// ignored.
module six_axis_report_conditioner import sarc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sarc_req_type        req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sarc_rsp_type        rsp_data,
   input  logic                csr_write,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   // configuration registers
   logic             enable_ff;
   logic [DzW-1:0]   dead_zone_ff;
   logic             cubic_ff;
   logic [GainW-1:0] move_gain_ff;
   logic [GainW-1:0] turn_gain_ff;
   logic             clear;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         dead_zone_ff <= DzReset;
         cubic_ff     <= 1'b1;
         move_gain_ff <= GainReset;
         turn_gain_ff <= GainReset;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_INPUT_ENABLE: enable_ff    <= csr_wdata[0];
            CSR_DEAD_ZONE:    dead_zone_ff <= csr_wdata[DzW-1:0];
            CSR_CUBIC_ENABLE: cubic_ff     <= csr_wdata[0];
            CSR_MOVE_GAIN:    move_gain_ff <= csr_wdata[GainW-1:0];
            CSR_TURN_GAIN:    turn_gain_ff <= csr_wdata[GainW-1:0];
            default: ;
         endcase
      end
   end

   // writing 0 to input_enable drops the stored vectors
   assign clear = csr_write && (csr_index == CSR_INPUT_ENABLE) && !csr_wdata[0];

   // classify a report as it transfers in
   kind_type kind_in;

   always_comb begin
      kind_in = KIND_NONE;
      if (enable_ff && req_data.report_length >= MinLen) begin
         if (req_data.report_id == IdMotion && req_data.report_length >= MotionLen) begin
            kind_in = KIND_MOTION;
         end else if (req_data.report_id == IdButton) begin
            kind_in = KIND_BUTTON;
         end
      end
   end

   // one report in flight; cnt tracks how far it has gone down the lanes
   sarc_req_type    item_ff;
   kind_type        kind_ff;
   logic            busy_ff;
   logic [CntW-1:0] cnt_ff;
   logic            accept;
   logic            done;
   logic            rsp_valid_ff;
   sarc_rsp_type    rsp_data_ff;

   assign done      = busy_ff && (cnt_ff == CntW'(LaneLatency)) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = busy_ff && !done;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
         kind_ff <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (accept) begin
         busy_ff <= (kind_in != KIND_NONE);
         cnt_ff  <= '0;
      end else begin
         if (done) busy_ff <= 1'b0;
         // advance until the last lane stage holds this report
         if (busy_ff && cnt_ff != CntW'(LaneLatency)) cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // six lanes: translation x y z then rotation x y z
   logic signed [AxisW-1:0] axes [NumAxes];
   logic signed [OutW-1:0]  lane_result [NumAxes];
   logic [GainW-1:0]        move_gain;
   logic [GainW-1:0]        turn_gain;

   assign move_gain = clamp_gain(move_gain_ff);
   assign turn_gain = clamp_gain(turn_gain_ff);

   assign axes[0] = item_ff.move_x;
   assign axes[1] = item_ff.move_y;
   assign axes[2] = item_ff.move_z;
   assign axes[3] = item_ff.turn_x;
   assign axes[4] = item_ff.turn_y;
   assign axes[5] = item_ff.turn_z;

   for (genvar g = 0; g < NumAxes; g++) begin : g_lane
      sarc_lane u_lane (
         .clock        (clock),
         .axis         (axes[g]),
         .dead_zone    (dead_zone_ff),
         .cubic_enable (cubic_ff),
         .gain         ((g >= 3) ? turn_gain : move_gain),
         .rot          ((g >= 3) ? 1'b1 : 1'b0),
         .result       (lane_result[g])
      );
   end

   // merge: compare, update stored state, build the result
   sarc_ctrl_type ctrl;
   logic          emit;
   sarc_rsp_type  merged;

   assign ctrl.commit  = done;
   assign ctrl.kind    = kind_ff;
   assign ctrl.buttons = item_ff.button_bits;

   sarc_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .clear       (clear),
      .ctrl        (ctrl),
      .lane_result (lane_result),
      .emit        (emit),
      .result      (merged)
   );

   // output register: load on commit, drop once the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done && emit) begin
         rsp_data_ff <= merged;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff <= CntW'(LaneLatency)))
      else $error("lane counter ran past the lane depth");

   a_rsp_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !done) |=> !rsp_valid)
      else $error("result repeated after its transfer");

   a_drop_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && kind_in == KIND_NONE) |=> !busy_ff)
      else $error("ignored report occupied the lanes");

endmodule

// ===== dv/six_axis_report_conditioner_tb.sv =====
`timescale 1ns / 100ps

module six_axis_report_conditioner_tb;
   import sarc_pkg::*;

   // Rounding shifts of the gain stage: rotation folds its factor of two into one
   // bit less of shift.
   localparam int unsigned MoveShift    = 8;
   localparam int unsigned TurnShift    = 7;
   // Unity in Q1.15 and the full-scale raw axis value.
   localparam longint unsigned Unity    = 64'd32768;
   localparam longint unsigned RawFull  = 64'd32767;
   // Quiet time before a register write or the end of the run. Reports that
   // give no result may still sit in the lanes when the last result arrives.
   localparam int SettleCycles          = 2 * (LaneLatency + 2);
   localparam int PhaseCount            = 9;
   localparam int PhaseReports          = 100;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   sarc_req_type        req_data;
   logic                rsp_valid;
   logic                rsp_stall;
   sarc_rsp_type        rsp_data;
   logic                csr_write;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   // Predictor copy of the registers and of the stored state.
   logic                   cfg_enable;
   logic [DzW-1:0]         cfg_dead_zone;
   logic                   cfg_cubic;
   logic [GainW-1:0]       cfg_move_gain;
   logic [GainW-1:0]       cfg_turn_gain;
   logic signed [OutW-1:0] stored_move [3];
   logic signed [OutW-1:0] stored_turn [3];
   logic                   held_left;
   logic                   held_right;

   sarc_rsp_type due_results [$];
   sarc_req_type recent_motion;
   int           error_count = 0;
   logic         idling_on;

   six_axis_report_conditioner i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Dead zone, Q1.15 normalize, optional cubic curve, then gain with one
   // rounding. Works on the magnitude and puts the sign back at the end.
   function automatic logic signed [OutW-1:0] shape_axis(
      input logic signed [AxisW-1:0] raw,
      input logic [GainW-1:0]        gain_reg,
      input int unsigned             shift
   );
      longint unsigned        mag;
      longint unsigned        gain;
      logic                   neg;
      logic signed [OutW-1:0] shaped;
      neg  = raw < 0;
      mag  = neg ? -longint'(raw) : longint'(raw);
      gain = gain_reg;
      if (gain_reg < 11'd26) gain = 64'd26;
      if (gain_reg > 11'd1280) gain = 64'd1280;
      // Magnitude test uses the true value, so the most negative raw is 32768.
      if (mag < cfg_dead_zone) return '0;
      mag = (mag * Unity * 2 + RawFull) / (2 * RawFull);
      if (mag > Unity) mag = Unity;
      if (cfg_cubic) mag = (mag * mag * mag + (64'd1 << 29)) >> 30;
      mag    = (mag * gain + (64'd1 << (shift - 1))) >> shift;
      shaped = mag[OutW-1:0];
      return neg ? -shaped : shaped;
   endfunction

   // Advance the predictor by one accepted report; queue the result it causes.
   task automatic predict_conditioned(input sarc_req_type item);
      logic signed [OutW-1:0] mv [3];
      logic signed [OutW-1:0] tv [3];
      logic                   move_diff;
      logic                   turn_diff;
      logic                   left_now;
      logic                   right_now;
      sarc_rsp_type           rsp;
      rsp = '0;
      if (!cfg_enable || item.report_length < MinLen) return;
      if (item.report_id == IdMotion) begin
         if (item.report_length < MotionLen) return;
         mv[0] = shape_axis(item.move_x, cfg_move_gain, MoveShift);
         mv[1] = -shape_axis(item.move_y, cfg_move_gain, MoveShift);
         mv[2] = -shape_axis(item.move_z, cfg_move_gain, MoveShift);
         tv[0] = shape_axis(item.turn_x, cfg_turn_gain, TurnShift);
         tv[1] = shape_axis(item.turn_y, cfg_turn_gain, TurnShift);
         tv[2] = shape_axis(item.turn_z, cfg_turn_gain, TurnShift);
         move_diff = 1'b0;
         turn_diff = 1'b0;
         for (int i = 0; i < 3; i++) begin
            if (mv[i] != stored_move[i]) move_diff = 1'b1;
            if (tv[i] != stored_turn[i]) turn_diff = 1'b1;
         end
         // Only a vector that changed is stored.
         if (move_diff) stored_move = mv;
         if (turn_diff) stored_turn = tv;
         if (!move_diff && !turn_diff) return;
         rsp.move_changed = move_diff;
         rsp.turn_changed = turn_diff;
         rsp.out_move_x   = stored_move[0];
         rsp.out_move_y   = stored_move[1];
         rsp.out_move_z   = stored_move[2];
         rsp.out_turn_x   = stored_turn[0];
         rsp.out_turn_y   = stored_turn[1];
         rsp.out_turn_z   = stored_turn[2];
         due_results.push_back(rsp);
      end else if (item.report_id == IdButton) begin
         left_now  = item.button_bits[BtnLeft];
         right_now = item.button_bits[BtnRight];
         rsp.left_press  = left_now && !held_left;
         rsp.right_press = right_now && !held_right;
         // Held bits follow every button report, with or without a press.
         held_left  = left_now;
         held_right = right_now;
         if (rsp.left_press || rsp.right_press) due_results.push_back(rsp);
      end
   endtask

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic signed [31:0] got,
                              input logic signed [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0d, predicted %0d", name, got, want));
   endtask

   // Compare every result transfer with the oldest prediction.
   always @(posedge clock) begin : result_checker
      sarc_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            report_mismatch("result transfer with no result predicted");
         end else begin
            want = due_results.pop_front();
            check_field("move_changed", rsp_data.move_changed, want.move_changed);
            check_field("turn_changed", rsp_data.turn_changed, want.turn_changed);
            check_field("out_move_x",   rsp_data.out_move_x,   want.out_move_x);
            check_field("out_move_y",   rsp_data.out_move_y,   want.out_move_y);
            check_field("out_move_z",   rsp_data.out_move_z,   want.out_move_z);
            check_field("out_turn_x",   rsp_data.out_turn_x,   want.out_turn_x);
            check_field("out_turn_y",   rsp_data.out_turn_y,   want.out_turn_y);
            check_field("out_turn_z",   rsp_data.out_turn_z,   want.out_turn_z);
            check_field("left_press",   rsp_data.left_press,   want.left_press);
            check_field("right_press",  rsp_data.right_press,  want.right_press);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Idling on both channels
   // ------------------------------------------------------------------------

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Stall the result channel in random bursts while idling is on.
   initial begin : rsp_backpressure
      int stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left == 0 && idling_on && $urandom_range(0, 2) == 0)
            stall_left = pick_gap();
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Transfer one report. Valid stays up afterwards, so the caller must either
   // send again or call settle_block before the next falling edge.
   task automatic send_report(input sarc_req_type item);
      int gap;
      gap = idling_on ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predict_conditioned(item);
   endtask

   // Drop valid, wait for every predicted result, then let the lanes empty.
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Write one register while the block is idle and mirror it in the predictor.
   task automatic write_register(input logic [CsrIdxW-1:0] index,
                                 input logic [CsrDataW-1:0] value);
      settle_block();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (index)
         CSR_INPUT_ENABLE: begin
            cfg_enable = value[0];
            if (!value[0]) begin
               stored_move = '{default: '0};
               stored_turn = '{default: '0};
            end
         end
         CSR_DEAD_ZONE:    cfg_dead_zone = value[DzW-1:0];
         CSR_CUBIC_ENABLE: cfg_cubic = value[0];
         CSR_MOVE_GAIN:    cfg_move_gain = value[GainW-1:0];
         CSR_TURN_GAIN:    cfg_turn_gain = value[GainW-1:0];
         default: ;
      endcase
   endtask

   function automatic sarc_req_type motion_report(
      input logic signed [AxisW-1:0] mx, my, mz, tx, ty, tz
   );
      sarc_req_type r;
      r               = '0;
      r.report_id     = IdMotion;
      r.report_length = MotionLen;
      r.move_x        = mx;
      r.move_y        = my;
      r.move_z        = mz;
      r.turn_x        = tx;
      r.turn_y        = ty;
      r.turn_z        = tz;
      return r;
   endfunction

   function automatic sarc_req_type button_report(input logic [7:0] bits);
      sarc_req_type r;
      r               = '0;
      r.report_id     = IdButton;
      r.report_length = MinLen;
      r.button_bits   = bits;
      return r;
   endfunction

   // One raw axis: full range, the extremes, zero, just around the dead zone,
   // or small values, down to where the cubic curve rounds to nothing.
   function automatic logic signed [AxisW-1:0] pick_axis();
      int near;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return AxisW'($urandom);
         4:          return '0;
         5:          return 16'sh8000;
         6:          return 16'sh7FFF;
         7: begin
            near = int'(cfg_dead_zone) + int'($urandom_range(0, 2)) - 1;
            return $urandom_range(0, 1) ? AxisW'(near) : AxisW'(-near);
         end
         default:    return AxisW'(int'($urandom_range(0, 4096)) - 2048);
      endcase
   endfunction

   // Mostly well-formed motion and button reports, some repeats of the last
   // motion (fully or with one axis moved), and some raw noise.
   function automatic sarc_req_type random_report();
      sarc_req_type r;
      int           roll;
      logic [127:0] noise;
      roll = $urandom_range(0, 99);
      if (roll < 15 && recent_motion.report_id == IdMotion) begin
         r = recent_motion;
         case ($urandom_range(0, 2))
            0: r.move_y = pick_axis();
            1: r.turn_z = pick_axis();
            default: ;
         endcase
      end else if (roll < 70) begin
         r             = motion_report(pick_axis(), pick_axis(), pick_axis(),
                                       pick_axis(), pick_axis(), pick_axis());
         r.button_bits = 8'($urandom);
         r.report_length = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(65, 127))
                                                       : 7'($urandom_range(13, 64));
      end else if (roll < 90) begin
         r = button_report(8'($urandom));
         r.report_length = 7'($urandom_range(7, 64));
         r.move_x        = AxisW'($urandom);
         r.turn_y        = AxisW'($urandom);
      end else begin
         noise = {$urandom, $urandom, $urandom, $urandom};
         r = noise[$bits(sarc_req_type)-1:0];
         r.report_length = 7'($urandom_range(0, 127));
      end
      if (r.report_id == IdMotion) recent_motion = r;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Out of reset the block is disabled: nothing comes back and the held
   // buttons stay released.
   task automatic test_disabled();
      send_report(motion_report(16'sd12000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd9000));
      send_report(button_report(8'h01));
   endtask

   // Enable only; dead zone, curve and gains run on their reset values.
   task automatic test_reset_defaults();
      write_register(CSR_INPUT_ENABLE, 15'd1);
      send_report(motion_report(16'sd1000, -16'sd1000, 16'sd49, -16'sd50,
                                16'sh7FFF, 16'sh8000));
      send_report(button_report(8'h01));
   endtask

   // Full-scale and unit axes with a linear curve and no dead zone.
   task automatic test_motion_extremes();
      write_register(CSR_CUBIC_ENABLE, 15'd0);
      write_register(CSR_DEAD_ZONE, 15'd0);
      send_report(motion_report(16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
      send_report(motion_report(16'sh8000, 16'sh8000, 16'sh8000,
                                16'sh8000, 16'sh8000, 16'sh8000));
      send_report(motion_report(16'sd1, -16'sd1, 16'sd0, -16'sd1, 16'sd1, 16'sd2));
   endtask

   // Short reports, short motion reports, long reports and unknown ids.
   task automatic test_length_rules();
      sarc_req_type r;
      r = motion_report(16'sd20000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      r.report_length = MinLen - 7'd1;
      send_report(r);
      r.report_length = MotionLen - 7'd1;
      send_report(r);
      r.report_length = 7'd127;
      send_report(r);
      // A short button report must not touch the held bits.
      r = button_report(8'h00);
      r.report_length = MinLen - 7'd1;
      send_report(r);
      r = button_report(8'h03);
      r.report_id     = 8'h02;
      r.report_length = 7'd64;
      send_report(r);
      r.report_id = 8'hFF;
      send_report(r);
   endtask

   // Repeat a motion report, then move only the rotation.
   task automatic test_repeat_motion();
      sarc_req_type r;
      r = motion_report(16'sd3000, -16'sd4000, 16'sd5000, 16'sd6000, -16'sd7000, 16'sd8000);
      send_report(r);
      send_report(r);
      r.turn_y = 16'sd100;
      send_report(r);
   endtask

   // Press, hold and release both buttons; upper bits of the byte don't count.
   task automatic test_buttons();
      send_report(button_report(8'h02));
      send_report(button_report(8'h03));
      send_report(button_report(8'h03));
      send_report(button_report(8'hFC));
      send_report(button_report(8'hFF));
   endtask

   // Gains below, at and above their limits; the widest dead zone.
   task automatic test_gain_limits();
      sarc_req_type r;
      r = motion_report(16'sh7FFF, -16'sd9000, 16'sd15000, 16'sh8000, 16'sd22222, -16'sd3);
      write_register(CSR_MOVE_GAIN, 15'd0);
      write_register(CSR_TURN_GAIN, 15'h7FFF);
      send_report(r);
      write_register(CSR_MOVE_GAIN, 15'd25);
      write_register(CSR_TURN_GAIN, 15'd1281);
      send_report(r);
      write_register(CSR_MOVE_GAIN, 15'd1280);
      write_register(CSR_TURN_GAIN, 15'd26);
      send_report(r);
      write_register(CSR_CUBIC_ENABLE, 15'd1);
      write_register(CSR_DEAD_ZONE, 15'h7FFF);
      send_report(motion_report(16'sh7FFF, 16'sh8000, 16'sd32766,
                                -16'sd32767, 16'sd0, 16'sh8000));
   endtask

   // Disabling clears the stored vectors, so a repeat gives a result again.
   task automatic test_disable_clears();
      sarc_req_type r;
      write_register(CSR_DEAD_ZONE, 15'd50);
      r = motion_report(16'sd10000, 16'sd10000, 16'sd0, 16'sd0, -16'sd10000, 16'sd0);
      send_report(r);
      write_register(CSR_INPUT_ENABLE, 15'h7FFE);
      write_register(CSR_INPUT_ENABLE, 15'd0);
      write_register(CSR_INPUT_ENABLE, 15'd1);
      send_report(r);
   endtask

   // Writes past the last register change nothing.
   task automatic test_unused_index();
      for (int k = int'(CSR_TURN_GAIN) + 1; k < (1 << CsrIdxW); k++)
         write_register(CsrIdxW'(k), CsrDataW'($urandom));
      send_report(motion_report(16'sd1, 16'sd30000, -16'sd30000, 16'sd777, 16'sd0, 16'sd5));
   endtask

   // Random reports under a series of settings, extremes first.
   task automatic test_random_phases();
      for (int p = 0; p < PhaseCount; p++) begin
         case (p)
            0: begin
               write_register(CSR_DEAD_ZONE, 15'd50);
               write_register(CSR_CUBIC_ENABLE, 15'd1);
               write_register(CSR_MOVE_GAIN, 15'd256);
               write_register(CSR_TURN_GAIN, 15'd256);
            end
            1: begin
               write_register(CSR_DEAD_ZONE, 15'd0);
               write_register(CSR_CUBIC_ENABLE, 15'd0);
               write_register(CSR_MOVE_GAIN, 15'd1280);
               write_register(CSR_TURN_GAIN, 15'd26);
            end
            2: begin
               write_register(CSR_DEAD_ZONE, 15'h7FFF);
               write_register(CSR_MOVE_GAIN, 15'd26);
               write_register(CSR_TURN_GAIN, 15'd1280);
            end
            3: begin
               write_register(CSR_DEAD_ZONE, 15'd1);
               write_register(CSR_CUBIC_ENABLE, 15'h7FFF);
               write_register(CSR_MOVE_GAIN, 15'd0);
               write_register(CSR_TURN_GAIN, 15'h7FF);
            end
            default: begin
               write_register(CSR_DEAD_ZONE, ($urandom_range(0, 4) == 0)
                              ? CsrDataW'($urandom) : CsrDataW'($urandom_range(0, 2000)));
               write_register(CSR_CUBIC_ENABLE, CsrDataW'($urandom_range(0, 1)));
               write_register(CSR_MOVE_GAIN, CsrDataW'($urandom_range(0, 2047)));
               write_register(CSR_TURN_GAIN, CsrDataW'($urandom_range(0, 2047)));
            end
         endcase
         // Some phases run flat out on both channels.
         idling_on = (p % 3 != 0);
         if (p == 5) begin
            write_register(CSR_INPUT_ENABLE, 15'd0);
            write_register(CSR_INPUT_ENABLE, 15'd1);
         end
         repeat (PhaseReports) send_report(random_report());
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_write     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      idling_on     = 1'b1;
      recent_motion = '0;
      cfg_enable    = 1'b0;
      cfg_dead_zone = DzReset;
      cfg_cubic     = 1'b1;
      cfg_move_gain = GainReset;
      cfg_turn_gain = GainReset;
      stored_move   = '{default: '0};
      stored_turn   = '{default: '0};
      held_left     = 1'b0;
      held_right    = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_disabled();
      test_reset_defaults();
      test_motion_extremes();
      test_length_rules();
      test_repeat_motion();
      test_buttons();
      test_gain_limits();
      test_disable_clears();
      test_unused_index();
      test_random_phases();

      settle_block();
      if (due_results.size() != 0)
         report_mismatch($sformatf("%0d predicted results never arrived", due_results.size()));
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
